[design/tcpaw_pkg.sv]
package tcpaw_pkg;

    // Send ring geometry (length must be a power of two)
    localparam int RING_LEN   = 4096;
    localparam int RING_IDX_W = $clog2(RING_LEN);
    localparam int RING_CNT_W = RING_IDX_W + 1;

    // Item kinds
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // One input word
    typedef struct packed {
        logic                  kind;
        logic [31:0]           seg_seq;
        logic [31:0]           seg_ack;
        logic [15:0]           seg_window;
        logic [31:0]           new_next_seq;
        logic                  syn_in_flight;
        logic                  fin_in_flight;
        logic [31:0]           fin_sequence;
        logic [RING_CNT_W-1:0] bytes_added;
    } item_t;

    // One result word
    typedef struct packed {
        logic [RING_CNT_W-1:0] acked_bytes;
        logic                  wake_writers;
        logic                  rtt_sample;
        logic                  restart_retransmit;
        logic                  clear_persist;
        logic                  send_data_req;
        logic                  send_ack_req;
        logic [RING_IDX_W-1:0] ring_start;
        logic [RING_CNT_W-1:0] ring_count;
        logic [31:0]           oldest_unacked;
        logic [15:0]           send_window;
    } result_t;

    // Modular sequence compare: a before b
    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    // Modular sequence compare: a not after b
    function automatic logic seq_not_after(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || seq_before(a, b);
    endfunction

endpackage

[design/tcpaw_item_if.sv]
interface tcpaw_item_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [31:0]                    seg_seq;
    logic [31:0]                    seg_ack;
    logic [15:0]                    seg_window;
    logic [31:0]                    new_next_seq;
    logic                           syn_in_flight;
    logic                           fin_in_flight;
    logic [31:0]                    fin_sequence;
    logic [tcpaw_pkg::RING_CNT_W-1:0] bytes_added;

    modport source (
        output valid, kind, seg_seq, seg_ack, seg_window, new_next_seq,
               syn_in_flight, fin_in_flight, fin_sequence, bytes_added,
        input  ready
    );

    modport sink (
        input  valid, kind, seg_seq, seg_ack, seg_window, new_next_seq,
               syn_in_flight, fin_in_flight, fin_sequence, bytes_added,
        output ready
    );
endinterface

[design/tcpaw_result_if.sv]
interface tcpaw_result_if;
    logic                             valid;
    logic                             ready;
    logic [tcpaw_pkg::RING_CNT_W-1:0] acked_bytes;
    logic                             wake_writers;
    logic                             rtt_sample;
    logic                             restart_retransmit;
    logic                             clear_persist;
    logic                             send_data_req;
    logic                             send_ack_req;
    logic [tcpaw_pkg::RING_IDX_W-1:0] ring_start;
    logic [tcpaw_pkg::RING_CNT_W-1:0] ring_count;
    logic [31:0]                      oldest_unacked;
    logic [15:0]                      send_window;

    modport source (
        output valid, acked_bytes, wake_writers, rtt_sample, restart_retransmit,
               clear_persist, send_data_req, send_ack_req, ring_start, ring_count,
               oldest_unacked, send_window,
        input  ready
    );

    modport sink (
        input  valid, acked_bytes, wake_writers, rtt_sample, restart_retransmit,
               clear_persist, send_data_req, send_ack_req, ring_start, ring_count,
               oldest_unacked, send_window,
        output ready
    );
endinterface

[design/tcpaw_core.sv]
module tcpaw_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  tcpaw_pkg::item_t   item,
    input  logic               fire,
    output tcpaw_pkg::result_t result
);

    localparam int IW = tcpaw_pkg::RING_IDX_W;
    localparam int CW = tcpaw_pkg::RING_CNT_W;

    // Connection state
    logic [31:0]   iss_reg;
    logic [31:0]   una_reg,        una_next;
    logic [31:0]   nxt_reg,        nxt_next;
    logic [15:0]   win_reg,        win_next;
    logic [31:0]   wl1_reg,        wl1_next;
    logic [31:0]   wl2_reg,        wl2_next;
    logic [IW-1:0] start_reg,      start_next;
    logic [CW-1:0] held_reg,       held_next;
    logic [63:0]   total_reg,      total_next;
    logic          syn_reg,        syn_next;
    logic          fin_reg,        fin_next;
    logic [31:0]   fin_seq_reg,    fin_seq_next;

    // Combinational work for the word in the input stage
    logic          ack_ok;
    logic [31:0]   raw_diff;
    logic [1:0]    less;
    logic [31:0]   acked_raw;
    logic [CW-1:0] acked;
    logic [CW-1:0] start_sum;
    logic [CW:0]   held_sum;
    logic          win_ok;
    logic [31:0]   old_end;
    logic [31:0]   new_end;

    always_comb
    begin
        una_next     = una_reg;
        nxt_next     = nxt_reg;
        win_next     = win_reg;
        wl1_next     = wl1_reg;
        wl2_next     = wl2_reg;
        start_next   = start_reg;
        held_next    = held_reg;
        total_next   = total_reg;
        syn_next     = syn_reg;
        fin_next     = fin_reg;
        fin_seq_next = fin_seq_reg;

        result = '0;

        // ACK acceptance and byte count
        ack_ok   = tcpaw_pkg::seq_before(una_reg, item.seg_ack)
                && tcpaw_pkg::seq_not_after(item.seg_ack, nxt_reg);
        raw_diff = item.seg_ack - una_reg;
        less     = {1'b0, syn_reg && (una_reg == iss_reg)}
                 + {1'b0, fin_reg && tcpaw_pkg::seq_before(fin_seq_reg, item.seg_ack)};
        acked_raw = (raw_diff > 32'(less)) ? raw_diff - 32'(less) : 32'd0;
        acked     = (acked_raw > 32'(held_reg)) ? held_reg : acked_raw[CW-1:0];
        start_sum = {1'b0, start_reg} + acked;

        // Window update ordering
        win_ok  = tcpaw_pkg::seq_before(wl1_reg, item.seg_seq)
               || ((wl1_reg == item.seg_seq)
                   && tcpaw_pkg::seq_not_after(wl2_reg, item.seg_ack));
        old_end = wl2_reg + 32'(win_reg);
        new_end = item.seg_ack + 32'(item.seg_window);

        // Sender update: saturating queue add
        held_sum = {1'b0, held_reg} + {1'b0, item.bytes_added};

        if (item.kind == tcpaw_pkg::KIND_UPDATE)
        begin
            nxt_next     = item.new_next_seq;
            syn_next     = item.syn_in_flight;
            fin_next     = item.fin_in_flight;
            fin_seq_next = item.fin_sequence;
            held_next    = (held_sum > (CW+1)'(tcpaw_pkg::RING_LEN))
                         ? CW'(tcpaw_pkg::RING_LEN) : held_sum[CW-1:0];
        end
        else
        begin
            if (ack_ok)
            begin
                start_next  = start_sum[IW-1:0];
                held_next   = held_reg - acked;
                total_next  = total_reg + 64'(acked);
                una_next    = item.seg_ack;
                result.acked_bytes        = acked;
                result.wake_writers       = (held_next < CW'(tcpaw_pkg::RING_LEN));
                result.rtt_sample         = 1'b1;
                result.restart_retransmit = tcpaw_pkg::seq_before(item.seg_ack, nxt_reg);
                result.send_data_req      = 1'b1;
            end
            if (win_ok)
            begin
                win_next = item.seg_window;
                wl1_next = item.seg_seq;
                wl2_next = item.seg_ack;
                if (!tcpaw_pkg::seq_not_after(new_end, old_end))
                begin
                    result.clear_persist = 1'b1;
                    result.send_data_req = 1'b1;
                end
            end
            result.send_ack_req = tcpaw_pkg::seq_before(nxt_reg, item.seg_ack);
        end

        result.ring_start     = start_next;
        result.ring_count     = held_next;
        result.oldest_unacked = una_next;
        result.send_window    = win_next;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg <= '0;
        end
        else if (cfg_we)
        begin
            iss_reg <= cfg_wdata;
        end
    end

    // State commits when the word moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            una_reg     <= '0;
            nxt_reg     <= '0;
            win_reg     <= '0;
            wl1_reg     <= '0;
            wl2_reg     <= '0;
            start_reg   <= '0;
            held_reg    <= '0;
            total_reg   <= '0;
            syn_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            fin_seq_reg <= '0;
        end
        else if (fire)
        begin
            una_reg     <= una_next;
            nxt_reg     <= nxt_next;
            win_reg     <= win_next;
            wl1_reg     <= wl1_next;
            wl2_reg     <= wl2_next;
            start_reg   <= start_next;
            held_reg    <= held_next;
            total_reg   <= total_next;
            syn_reg     <= syn_next;
            fin_reg     <= fin_next;
            fin_seq_reg <= fin_seq_next;
        end
    end

endmodule

[design/tcp_ack_window_update.sv]
// Stages: a word accepted from item_in is held in the input register, then
// its result word is held in the result register until the sink takes it.
// Throughput: one word per cycle; the input register and result register
// stall together only while the result word is held by the sink.
// Reset (rst_n, async, active low) empties both stages and zeroes all core state.
module tcp_ack_window_update (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    tcpaw_item_if.sink     item_in,
    tcpaw_result_if.source result_out
);

    logic               in_valid_reg;
    tcpaw_pkg::item_t   in_word_reg;
    logic               out_valid_reg;
    tcpaw_pkg::result_t out_word_reg;
    tcpaw_pkg::result_t core_result;
    tcpaw_pkg::item_t   in_word;
    logic               advance;
    logic               in_take;

    // Pipeline handshake
    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !in_valid_reg || advance;
    assign in_take       = item_in.valid && item_in.ready;

    // Gather input word
    always_comb
    begin
        in_word.kind          = item_in.kind;
        in_word.seg_seq       = item_in.seg_seq;
        in_word.seg_ack       = item_in.seg_ack;
        in_word.seg_window    = item_in.seg_window;
        in_word.new_next_seq  = item_in.new_next_seq;
        in_word.syn_in_flight = item_in.syn_in_flight;
        in_word.fin_in_flight = item_in.fin_in_flight;
        in_word.fin_sequence  = item_in.fin_sequence;
        in_word.bytes_added   = item_in.bytes_added;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_word_reg <= in_word;
        if (advance)
            out_word_reg <= core_result;
    end

    tcpaw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (in_word_reg),
        .fire      (advance),
        .result    (core_result)
    );

    // Result word out
    assign result_out.valid              = out_valid_reg;
    assign result_out.acked_bytes        = out_word_reg.acked_bytes;
    assign result_out.wake_writers       = out_word_reg.wake_writers;
    assign result_out.rtt_sample         = out_word_reg.rtt_sample;
    assign result_out.restart_retransmit = out_word_reg.restart_retransmit;
    assign result_out.clear_persist      = out_word_reg.clear_persist;
    assign result_out.send_data_req      = out_word_reg.send_data_req;
    assign result_out.send_ack_req       = out_word_reg.send_ack_req;
    assign result_out.ring_start         = out_word_reg.ring_start;
    assign result_out.ring_count         = out_word_reg.ring_count;
    assign result_out.oldest_unacked     = out_word_reg.oldest_unacked;
    assign result_out.send_window        = out_word_reg.send_window;

endmodule
